### rtl/esrk_pkg.sv
// Package with the transaction types and controller/datapath interface structs of the record sorter.
package esrk_pkg;

	typedef struct packed {
		logic [7:0] sort_key;
		logic [9:0] record_tag;
		logic       last_item;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_key;
		logic [9:0] out_tag;
		logic       out_last;
		logic       overflowed;
	} result_t;

	typedef struct packed {
		logic [7:0] key;
		logic [9:0] tag;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_outer;
		logic rd_next;
		logic hold;
		logic scan;
		logic wb;
		logic emit_init;
		logic emit;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic outer_done;
		logic more;
	} dp_stat_t;

endpackage

### rtl/esrk_datapath.sv
// Datapath of the record sorter: entry memory, indices, held entry and compare-swap logic.
module esrk_datapath #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esrk_pkg::in_item_t in_item,
	input  esrk_pkg::dp_cmd_t  cmd,
	output esrk_pkg::dp_stat_t stat,
	output esrk_pkg::result_t  result
);
	import esrk_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	entry_t        mem [MAX_ENTRIES];
	entry_t        rdata_q;
	entry_t        held_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] jd_q;
	logic          ovf_q;

	logic          full;
	logic          swap;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	logic          re;

	assign full = (count_q == CW'(MAX_ENTRIES));
	assign swap = cmd.scan && (held_q.key > rdata_q.key);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = held_q;
		if (cmd.load && !full) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = '{key: in_item.sort_key, tag: in_item.record_tag};
		end else if (swap) begin
			we    = 1'b1;
			waddr = jd_q[AW-1:0];
		end else if (cmd.wb) begin
			we    = 1'b1;
			waddr = i_q[AW-1:0];
		end
	end

	assign re    = cmd.rd_outer || cmd.rd_next;
	assign raddr = cmd.rd_outer ? i_q[AW-1:0] : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (cmd.hold || swap) begin
			held_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			jd_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.rd_outer) begin
				j_q <= i_q + 1'b1;
			end else if (cmd.rd_next) begin
				j_q  <= j_q + 1'b1;
				jd_q <= j_q;
			end else if (cmd.emit_init) begin
				j_q <= '0;
			end
			if (cmd.wb) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.clear) begin
				count_q <= '0;
				i_q     <= '0;
				j_q     <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign stat.outer_done = ((i_q + 1'b1) >= count_q);
	assign stat.more       = (j_q < count_q);

	assign result.out_key    = rdata_q.key;
	assign result.out_tag    = rdata_q.tag;
	assign result.out_last   = (jd_q == (count_q - 1'b1));
	assign result.overflowed = ovf_q;

endmodule

### rtl/esrk_ctrl.sv
// Controller state machine of the record sorter: load, exchange sort sweeps and emission.
module esrk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               last_item,
	input  esrk_pkg::dp_stat_t stat,
	output esrk_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               result_strobe
);
	import esrk_pkg::*;

	typedef enum logic [6:0] {
		S_LOAD    = 7'b0000001,
		S_OUTER   = 7'b0000010,
		S_HOLD    = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_WB      = 7'b0010000,
		S_EMIT_RD = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_item) begin
						state_d = S_OUTER;
					end
				end
			end
			S_OUTER: begin
				if (stat.outer_done) begin
					cmd.emit_init = 1'b1;
					state_d       = S_EMIT_RD;
				end else begin
					cmd.rd_outer = 1'b1;
					state_d      = S_HOLD;
				end
			end
			S_HOLD: begin
				cmd.hold    = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.more) begin
					cmd.rd_next = 1'b1;
				end else begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_OUTER;
			end
			S_EMIT_RD: begin
				cmd.rd_next = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.more) begin
					cmd.rd_next = 1'b1;
				end else begin
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy          = (state_q != S_LOAD);
	assign result_strobe = cmd.emit;

endmodule

### rtl/exchange_sort_records_by_key_top.sv
// Top level of the record sorter that joins controller and datapath.
//
// Input transactions carry one record (8-bit key, 10-bit tag, last flag) and are
// taken at a rising edge with start high and busy low, one per cycle while loading.
// A record with last_item set ends the list; busy then rises and the block sorts
// the stored entries with an exchange sort, one compare-swap per cycle during each scan, through a
// single-read, single-write entry memory. Records beyond MAX_ENTRIES are dropped
// and reported through overflowed on every result of that list.
// Each outer index but the last holds its entry, scans the later entries with it
// and writes the held entry back; emission then reads the entries in index order.
// Results appear for one cycle each, marked by result_strobe, in ascending key
// order, with out_last on the final one; the receiver cannot stall them.
// Busy falls in the cycle after the final result and loading of a new list starts.
// Reset clears the entry count, the overflow flag and returns to loading; stored
// entries are not cleared and need no clearing pass.
module exchange_sort_records_by_key_top #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  esrk_pkg::in_item_t in_item,
	output logic               result_strobe,
	output esrk_pkg::result_t  result
);
	import esrk_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	esrk_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_item     (in_item.last_item),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	esrk_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("Result strobe outside a busy period.");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_item.last_item) |=> busy)
		else $error("Final record did not start the sort.");

	a_final_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.out_last) |=> !busy)
		else $error("Block stayed busy after the final result.");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && in_item.last_item))
		else $error("Busy rose without a final record.");

endmodule
